[rtl/core/bxavg_pkg.sv]
// Shared constants, codes and controller/datapath bundles of the box-average downscaler.
`timescale 1ns / 1ps
package bxavg_pkg;

  localparam int OUT_SIZE_DEF = 64;
  localparam int MAX_DIM_DEF  = 1024;
  localparam int MIN_DIM      = 64;
  localparam int CFG_W        = 11;
  localparam int PIX_W        = 8;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  typedef enum logic [0:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } reg_idx_t;

  // Operand selection of the shared divider.
  typedef enum logic [2:0] {
    DSEL_COL   = 3'd0,
    DSEL_ROW   = 3'd1,
    DSEL_NEXT  = 3'd2,
    DSEL_RED   = 3'd3,
    DSEL_GREEN = 3'd4,
    DSEL_BLUE  = 3'd5
  } dsel_t;

  typedef struct packed {
    logic  load_px;
    logic  div_start;
    dsel_t div_sel;
    logic  mem_rd;
    logic  mem_wr;
    logic  burst_rd;
    logic  out_load;
    logic  burst_next;
    logic  band_clear;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic row_end;
    logic frame_end;
    logic band_end;
    logic last_cell;
    logic out_free;
  } stat_t;

endpackage

[rtl/core/bxavg_if.sv]
// Pixel request channel and result request channel interfaces.
`timescale 1ns / 1ps
interface bxavg_in_if;
  logic                         valid;
  logic                         ready;
  logic [bxavg_pkg::PIX_W-1:0]  red_in;
  logic [bxavg_pkg::PIX_W-1:0]  green_in;
  logic [bxavg_pkg::PIX_W-1:0]  blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bxavg_out_if #(parameter int COL_W = 6);
  logic                         valid;
  logic                         ready;
  logic [bxavg_pkg::PIX_W-1:0]  red_out;
  logic [bxavg_pkg::PIX_W-1:0]  green_out;
  logic [bxavg_pkg::PIX_W-1:0]  blue_out;
  logic [COL_W-1:0]             cell_column;
  logic [COL_W-1:0]             cell_row;
  logic                         band_last;
  logic                         frame_last;

  modport source (output valid, red_out, green_out, blue_out, cell_column, cell_row,
                  band_last, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, cell_column, cell_row,
                  band_last, frame_last, output ready);
endinterface

[rtl/core/bxavg_div.sv]
// Restoring divider, one quotient bit per cycle, quotient known to fit Q_W bits.
`timescale 1ns / 1ps
module bxavg_div #(
  parameter int N_W = 21,
  parameter int D_W = 11,
  parameter int Q_W = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [Q_W-1:0] quo
);

  localparam int DS_W  = D_W + Q_W;
  localparam int CMP_W = (N_W > DS_W) ? N_W : DS_W;
  localparam int CW    = $clog2(Q_W + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [N_W-1:0]  rem_r, rem_nxt;
  logic [DS_W-1:0] dsh_r, dsh_nxt;
  logic [Q_W-1:0]  q_r, q_nxt;
  logic            fits;

  assign fits = CMP_W'(rem_r) >= CMP_W'(dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(Q_W);
      rem_nxt  = num;
      dsh_nxt  = DS_W'(den) << (Q_W - 1);
      q_nxt    = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - N_W'(dsh_r);
      end
      q_nxt   = {q_r[Q_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

[rtl/core/bxavg_dp.sv]
// Datapath: position tracking, column accumulator memory, shared divider and result register.
`timescale 1ns / 1ps
module bxavg_dp #(
  parameter int OUT_SIZE       = bxavg_pkg::OUT_SIZE_DEF,
  parameter int MAX_SOURCE_DIM = bxavg_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bxavg_pkg::CFG_W-1:0]       src_width,
  input  logic [bxavg_pkg::CFG_W-1:0]       src_height,
  input  logic [bxavg_pkg::PIX_W-1:0]       red_in,
  input  logic [bxavg_pkg::PIX_W-1:0]       green_in,
  input  logic [bxavg_pkg::PIX_W-1:0]       blue_in,
  input  bxavg_pkg::cmd_t                   cmd,
  output bxavg_pkg::stat_t                  stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bxavg_pkg::PIX_W-1:0]       red_out,
  output logic [bxavg_pkg::PIX_W-1:0]       green_out,
  output logic [bxavg_pkg::PIX_W-1:0]       blue_out,
  output logic [$clog2(OUT_SIZE)-1:0]       cell_column,
  output logic [$clog2(OUT_SIZE)-1:0]       cell_row,
  output logic                              band_last,
  output logic                              frame_last
);

  localparam int PIX_W  = bxavg_pkg::PIX_W;
  localparam int DIM_W  = bxavg_pkg::CFG_W;
  localparam int COL_W  = $clog2(OUT_SIZE);
  localparam int POS_W  = $clog2(MAX_SOURCE_DIM);
  localparam int XW     = (POS_W > DIM_W) ? POS_W : DIM_W;
  localparam int CELL   = (MAX_SOURCE_DIM + OUT_SIZE - 1) / OUT_SIZE;
  localparam int CNT_W  = $clog2(CELL * CELL + 1);
  localparam int SUM_W  = PIX_W + CNT_W;
  localparam int MUL_W  = $clog2(OUT_SIZE + 1);
  localparam int POSN_W = POS_W + MUL_W;
  localparam int N_W    = (POSN_W > SUM_W) ? POSN_W : SUM_W;
  localparam int D_W    = (DIM_W > CNT_W) ? DIM_W : CNT_W;
  localparam int Q_W    = (COL_W > PIX_W) ? COL_W : PIX_W;
  localparam int ENT_W  = 3 * SUM_W + CNT_W;

  // Effective source size, saturated to the supported range.
  logic [DIM_W-1:0] w, h;
  always_comb begin
    priority if (src_width < DIM_W'(bxavg_pkg::MIN_DIM)) w = DIM_W'(bxavg_pkg::MIN_DIM);
    else if (XW'(src_width) > XW'(MAX_SOURCE_DIM))       w = DIM_W'(MAX_SOURCE_DIM);
    else                                                 w = src_width;
    priority if (src_height < DIM_W'(bxavg_pkg::MIN_DIM)) h = DIM_W'(bxavg_pkg::MIN_DIM);
    else if (XW'(src_height) > XW'(MAX_SOURCE_DIM))       h = DIM_W'(MAX_SOURCE_DIM);
    else                                                  h = src_height;
  end

  logic [POS_W-1:0]     sc_r, sr_r, x_r, y_r;
  logic [3*PIX_W-1:0]   px_r;
  logic [COL_W-1:0]     col_r, row_r, next_r, j_r;
  logic [PIX_W-1:0]     red_q_r, green_q_r, blue_q_r;
  bxavg_pkg::dsel_t     dsel_r;
  logic [OUT_SIZE-1:0]  valid_r;
  logic [ENT_W-1:0]     mem [OUT_SIZE];
  logic [ENT_W-1:0]     rd_q;
  logic                 rd_v;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     red_o_r, green_o_r, blue_o_r;
  logic [COL_W-1:0]     col_o_r, row_o_r;
  logic                 band_o_r, frame_o_r;

  logic row_end, frame_end;
  assign row_end   = XW'(x_r) == XW'(w) - XW'(1);
  assign frame_end = row_end && (XW'(y_r) == XW'(h) - XW'(1));

  // Entry read back from the accumulator memory; an entry not written this band reads as zero.
  logic [ENT_W-1:0] rd_ent;
  logic [SUM_W-1:0] e_red, e_green, e_blue;
  logic [CNT_W-1:0] e_cnt;
  assign rd_ent = rd_v ? rd_q : '0;
  assign {e_red, e_green, e_blue, e_cnt} = rd_ent;

  logic [ENT_W-1:0] wr_ent;
  assign wr_ent = {e_red   + SUM_W'(px_r[3*PIX_W-1:2*PIX_W]),
                   e_green + SUM_W'(px_r[2*PIX_W-1:PIX_W]),
                   e_blue  + SUM_W'(px_r[PIX_W-1:0]),
                   e_cnt   + CNT_W'(1)};

  // Divider operands.
  logic [N_W-1:0] d_num;
  logic [D_W-1:0] d_den;
  logic           d_done;
  logic [Q_W-1:0] d_quo;
  always_comb begin
    unique case (cmd.div_sel)
      bxavg_pkg::DSEL_COL: begin
        d_num = N_W'(x_r) * N_W'(OUT_SIZE);
        d_den = D_W'(w);
      end
      bxavg_pkg::DSEL_ROW: begin
        d_num = N_W'(y_r) * N_W'(OUT_SIZE);
        d_den = D_W'(h);
      end
      bxavg_pkg::DSEL_NEXT: begin
        d_num = (N_W'(y_r) + N_W'(1)) * N_W'(OUT_SIZE);
        d_den = D_W'(h);
      end
      bxavg_pkg::DSEL_RED: begin
        d_num = N_W'(e_red);
        d_den = D_W'(e_cnt);
      end
      bxavg_pkg::DSEL_GREEN: begin
        d_num = N_W'(e_green);
        d_den = D_W'(e_cnt);
      end
      bxavg_pkg::DSEL_BLUE: begin
        d_num = N_W'(e_blue);
        d_den = D_W'(e_cnt);
      end
      default: begin
        d_num = '0;
        d_den = '0;
      end
    endcase
  end

  bxavg_div #(.N_W(N_W), .D_W(D_W), .Q_W(Q_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (d_num),
    .den   (d_den),
    .done  (d_done),
    .quo   (d_quo)
  );

  logic [PIX_W-1:0] mean;
  assign mean = (e_cnt == '0) ? '0 : PIX_W'(d_quo);

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      x_r  <= (XW'(sc_r) < XW'(w)) ? sc_r : POS_W'(w - DIM_W'(1));
      y_r  <= (XW'(sr_r) < XW'(h)) ? sr_r : POS_W'(h - DIM_W'(1));
      px_r <= {red_in, green_in, blue_in};
    end
    if (cmd.div_start) begin
      dsel_r <= cmd.div_sel;
    end
    if (d_done) begin
      unique case (dsel_r)
        bxavg_pkg::DSEL_COL:   col_r     <= COL_W'(d_quo);
        bxavg_pkg::DSEL_ROW:   row_r     <= COL_W'(d_quo);
        bxavg_pkg::DSEL_NEXT:  next_r    <= COL_W'(d_quo);
        bxavg_pkg::DSEL_RED:   red_q_r   <= mean;
        bxavg_pkg::DSEL_GREEN: green_q_r <= mean;
        bxavg_pkg::DSEL_BLUE:  blue_q_r  <= mean;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      red_o_r   <= red_q_r;
      green_o_r <= green_q_r;
      blue_o_r  <= blue_q_r;
      col_o_r   <= j_r;
      row_o_r   <= row_r;
      band_o_r  <= stat.last_cell;
      frame_o_r <= stat.last_cell && frame_end;
    end
  end

  // Accumulator memory, one entry per output column.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[col_r] <= wr_ent;
    end
    if (cmd.mem_rd || cmd.burst_rd) begin
      rd_q <= mem[cmd.burst_rd ? j_r : col_r];
      rd_v <= valid_r[cmd.burst_rd ? j_r : col_r];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r        <= '0;
      sr_r        <= '0;
      j_r         <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mem_wr) begin
        valid_r[col_r] <= 1'b1;
        if (row_end) begin
          sc_r <= '0;
          sr_r <= frame_end ? '0 : y_r + POS_W'(1);
        end else begin
          sc_r <= x_r + POS_W'(1);
          sr_r <= y_r;
        end
      end
      if (cmd.band_clear) begin
        valid_r <= '0;
        j_r     <= '0;
      end else if (cmd.burst_next) begin
        j_r <= j_r + COL_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.div_done  = d_done;
    stat.row_end   = row_end;
    stat.frame_end = frame_end;
    stat.band_end  = row_end && (frame_end || next_r != row_r);
    stat.last_cell = j_r == COL_W'(OUT_SIZE - 1);
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign red_out     = red_o_r;
  assign green_out   = green_o_r;
  assign blue_out    = blue_o_r;
  assign cell_column = col_o_r;
  assign cell_row    = row_o_r;
  assign band_last   = band_o_r;
  assign frame_last  = frame_o_r;

endmodule

[rtl/core/bxavg_ctrl.sv]
// Controller state machine: sequences pixel accumulation and the per-band result burst.
`timescale 1ns / 1ps
module bxavg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bxavg_pkg::stat_t  stat,
  output bxavg_pkg::cmd_t   cmd
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_COL  = 16'h0002,
    S_COLW = 16'h0004,
    S_ROW  = 16'h0008,
    S_ROWW = 16'h0010,
    S_NXT  = 16'h0020,
    S_NXTW = 16'h0040,
    S_RD   = 16'h0080,
    S_WR   = 16'h0100,
    S_BRD  = 16'h0200,
    S_BR   = 16'h0400,
    S_BRW  = 16'h0800,
    S_BG   = 16'h1000,
    S_BGW  = 16'h2000,
    S_BB   = 16'h4000,
    S_BBW  = 16'h8000
  } state_t;

  // The result hand-off shares the blue wait state once the divider is done.
  state_t state_r, state_nxt;
  logic   out_pend_r, out_pend_nxt;

  always_comb begin
    state_nxt    = state_r;
    out_pend_nxt = out_pend_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_px = 1'b1;
          state_nxt   = S_COL;
        end
      end
      S_COL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bxavg_pkg::DSEL_COL;
        state_nxt     = S_COLW;
      end
      S_COLW: if (stat.div_done) state_nxt = S_ROW;
      S_ROW: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bxavg_pkg::DSEL_ROW;
        state_nxt     = S_ROWW;
      end
      S_ROWW: begin
        if (stat.div_done) begin
          state_nxt = (stat.row_end && !stat.frame_end) ? S_NXT : S_RD;
        end
      end
      S_NXT: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bxavg_pkg::DSEL_NEXT;
        state_nxt     = S_NXTW;
      end
      S_NXTW: if (stat.div_done) state_nxt = S_RD;
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        state_nxt  = stat.band_end ? S_BRD : S_IDLE;
      end
      S_BRD: begin
        cmd.burst_rd = 1'b1;
        state_nxt    = S_BR;
      end
      S_BR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bxavg_pkg::DSEL_RED;
        state_nxt     = S_BRW;
      end
      S_BRW: if (stat.div_done) state_nxt = S_BG;
      S_BG: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bxavg_pkg::DSEL_GREEN;
        state_nxt     = S_BGW;
      end
      S_BGW: if (stat.div_done) state_nxt = S_BB;
      S_BB: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bxavg_pkg::DSEL_BLUE;
        state_nxt     = S_BBW;
        out_pend_nxt  = 1'b0;
      end
      S_BBW: begin
        if (stat.div_done) begin
          out_pend_nxt = 1'b1;
        end
        if (out_pend_r && stat.out_free) begin
          cmd.out_load = 1'b1;
          out_pend_nxt = 1'b0;
          if (stat.last_cell) begin
            cmd.band_clear = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.burst_next = 1'b1;
            state_nxt      = S_BRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_pend_r <= out_pend_nxt;
    end
  end

endmodule

[rtl/core/box_average_image_downscale_top.sv]
// Box-average image downscaler: RGB pixels in raster order are averaged into an
// OUT_SIZE x OUT_SIZE grid. Each accepted pixel passes through the shared bit-serial divider
// (quotient width 8 at the default size) and is added into the accumulator memory before
// the next pixel is taken; the last pixel of a source row, but for the last of the frame,
// also gets a next-band check. The cell column and row of every pixel come from that
// divider. When a band of source rows ends, the block emits OUT_SIZE results, each needing
// three mean divisions and a memory read; no pixel is taken during that burst. Source width
// and height are set through the register port at byte addresses 0 and 4 and are saturated
// to the range 64 to MAX_SOURCE_DIM.
`timescale 1ns / 1ps
module box_average_image_downscale_top #(
  parameter int OUT_SIZE       = bxavg_pkg::OUT_SIZE_DEF,
  parameter int MAX_SOURCE_DIM = bxavg_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bxavg_in_if.sink                       in_px,
  bxavg_out_if.source                    out_px,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bxavg_pkg::APB_AW-1:0]   paddr,
  input  logic [bxavg_pkg::APB_DW-1:0]   pwdata,
  output logic [bxavg_pkg::APB_DW-1:0]   prdata,
  output logic                           pready
);

  localparam int CFG_W = bxavg_pkg::CFG_W;

  logic [CFG_W-1:0]  width_r, height_r;
  bxavg_pkg::reg_idx_t reg_idx;
  bxavg_pkg::cmd_t   cmd;
  bxavg_pkg::stat_t  stat;
  logic [$clog2(OUT_SIZE)-1:0] cell_column, cell_row;

  assign reg_idx = bxavg_pkg::reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(bxavg_pkg::MIN_DIM);
      height_r <= CFG_W'(bxavg_pkg::MIN_DIM);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        bxavg_pkg::REG_SRC_WIDTH:  width_r  <= pwdata[CFG_W-1:0];
        bxavg_pkg::REG_SRC_HEIGHT: height_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bxavg_pkg::REG_SRC_WIDTH:  prdata = bxavg_pkg::APB_DW'(width_r);
      bxavg_pkg::REG_SRC_HEIGHT: prdata = bxavg_pkg::APB_DW'(height_r);
      default:                   prdata = '0;
    endcase
  end

  bxavg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_px.valid),
    .in_ready (in_px.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bxavg_dp #(.OUT_SIZE(OUT_SIZE), .MAX_SOURCE_DIM(MAX_SOURCE_DIM)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .src_width   (width_r),
    .src_height  (height_r),
    .red_in      (in_px.red_in),
    .green_in    (in_px.green_in),
    .blue_in     (in_px.blue_in),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_px.valid),
    .out_ready   (out_px.ready),
    .red_out     (out_px.red_out),
    .green_out   (out_px.green_out),
    .blue_out    (out_px.blue_out),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .band_last   (out_px.band_last),
    .frame_last  (out_px.frame_last)
  );

  assign out_px.cell_column = cell_column;
  assign out_px.cell_row    = cell_row;

endmodule

[rtl/core/bxavg_chk.sv]
// Port-level checker for the box-average downscaler, bound to the top level.
`timescale 1ns / 1ps
module bxavg_chk #(
  parameter int OUT_SIZE = bxavg_pkg::OUT_SIZE_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_band_last,
  input logic                        out_frame_last,
  input logic [$clog2(OUT_SIZE)-1:0] out_cell_column,
  input logic                        pready
);

  localparam int COL_W = $clog2(OUT_SIZE);

  // A result request that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // The end of the image is always also the end of a band.
  a_frame_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_band_last)
    else $error("frame_last without band_last");

  // A band ends on its rightmost cell.
  a_band_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_band_last |-> out_cell_column == COL_W'(OUT_SIZE - 1))
    else $error("band_last on a cell other than the last column");

  // No pixel is taken while a band's burst is still under way.
  a_burst_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_band_last |-> !in_ready)
    else $error("pixel request taken during a band burst");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("register port stalled");

endmodule

bind box_average_image_downscale_top bxavg_chk #(.OUT_SIZE(OUT_SIZE)) u_bxavg_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_px.ready),
  .out_valid       (out_px.valid),
  .out_ready       (out_px.ready),
  .out_band_last   (out_px.band_last),
  .out_frame_last  (out_px.frame_last),
  .out_cell_column (out_px.cell_column),
  .pready          (pready)
);

[tb/tb_box_average_image_downscale_top.sv]
// Self-checking testbench of the box-average image downscaler top level.
`timescale 1ns / 1ps
module tb_box_average_image_downscale_top;

  localparam int GRID = 64;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] column;
    logic [5:0] row;
    logic       band_last;
    logic       frame_last;
  } cell_mean_t;

  // Scoreboard: keeps its own band accumulators and the queue of expected cell means.
  class cell_mean_scoreboard;
    logic [10:0]  width_reg;
    logic [10:0]  height_reg;
    int unsigned  red_acc[GRID];
    int unsigned  green_acc[GRID];
    int unsigned  blue_acc[GRID];
    int unsigned  pixel_cnt[GRID];
    int unsigned  src_x;
    int unsigned  src_y;
    cell_mean_t   expected_means[$];
    int           errors;
    int           checked;
    int           bands_done;

    function new();
      width_reg  = 11'd64;
      height_reg = 11'd64;
      src_x      = 0;
      src_y      = 0;
      errors     = 0;
      checked    = 0;
      bands_done = 0;
      clear_band();
    endfunction

    function void clear_band();
      for (int j = 0; j < GRID; j++) begin
        red_acc[j]   = 0;
        green_acc[j] = 0;
        blue_acc[j]  = 0;
        pixel_cnt[j] = 0;
      end
    endfunction

    function void write_reg(bxavg_pkg::reg_idx_t idx, logic [10:0] value);
      if (idx == bxavg_pkg::REG_SRC_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    function int unsigned sat_dim(logic [10:0] v);
      if (v < bxavg_pkg::MIN_DIM) return bxavg_pkg::MIN_DIM;
      if (v > bxavg_pkg::MAX_DIM_DEF) return bxavg_pkg::MAX_DIM_DEF;
      return v;
    endfunction

    function int unsigned cell_index(int unsigned pos, int unsigned dim);
      int unsigned c;
      c = (pos * GRID) / dim;
      return (c > GRID - 1) ? GRID - 1 : c;
    endfunction

    function logic [7:0] mean8(int unsigned sum, int unsigned cnt);
      if (cnt == 0) return 8'd0;
      return 8'(sum / cnt);
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, x, y, col, row;
      bit row_end, frame_end, band_end;
      cell_mean_t m;
      w = sat_dim(width_reg);
      h = sat_dim(height_reg);
      // A register change mid-frame pins the position to the new edge.
      x = (src_x < w) ? src_x : w - 1;
      y = (src_y < h) ? src_y : h - 1;
      col = cell_index(x, w);
      row = cell_index(y, h);
      row_end   = (x == w - 1);
      frame_end = row_end && (y == h - 1);
      band_end  = row_end && (frame_end || cell_index(y + 1, h) != row);
      red_acc[col]   += r;
      green_acc[col] += g;
      blue_acc[col]  += b;
      pixel_cnt[col] += 1;
      if (band_end) begin
        for (int j = 0; j < GRID; j++) begin
          m.red        = mean8(red_acc[j], pixel_cnt[j]);
          m.green      = mean8(green_acc[j], pixel_cnt[j]);
          m.blue       = mean8(blue_acc[j], pixel_cnt[j]);
          m.column     = j[5:0];
          m.row        = row[5:0];
          m.band_last  = (j == GRID - 1);
          m.frame_last = (j == GRID - 1) && frame_end;
          expected_means = {expected_means, m};
        end
        clear_band();
      end
      if (row_end) begin
        src_x = 0;
        src_y = frame_end ? 0 : y + 1;
      end else begin
        src_x = x + 1;
        src_y = y;
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(cell_mean_t got);
      cell_mean_t exp_m;
      if (expected_means.size() == 0) begin
        report($sformatf("unexpected result col %0d row %0d", got.column, got.row));
        return;
      end
      exp_m = expected_means.pop_front();
      checked++;
      if (got.band_last === 1'b1) bands_done++;
      if (got.red !== exp_m.red)
        report($sformatf("red %0d, expected %0d", got.red, exp_m.red));
      if (got.green !== exp_m.green)
        report($sformatf("green %0d, expected %0d", got.green, exp_m.green));
      if (got.blue !== exp_m.blue)
        report($sformatf("blue %0d, expected %0d", got.blue, exp_m.blue));
      if (got.column !== exp_m.column)
        report($sformatf("cell_column %0d, expected %0d", got.column, exp_m.column));
      if (got.row !== exp_m.row)
        report($sformatf("cell_row %0d, expected %0d", got.row, exp_m.row));
      if (got.band_last !== exp_m.band_last)
        report($sformatf("band_last %0b, expected %0b", got.band_last, exp_m.band_last));
      if (got.frame_last !== exp_m.frame_last)
        report($sformatf("frame_last %0b, expected %0b", got.frame_last, exp_m.frame_last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bxavg_pkg::APB_AW-1:0] paddr;
  logic [bxavg_pkg::APB_DW-1:0] pwdata;
  logic [bxavg_pkg::APB_DW-1:0] prdata;
  logic pready;

  bxavg_in_if in_px();
  bxavg_out_if #(.COL_W(6)) out_px();

  box_average_image_downscale_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (in_px.sink),
    .out_px  (out_px.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cell_mean_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 0;
  int pixels_sent    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", sb.expected_means.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: checks every accepted request and drives ready, with an optional
  // long hold-off so the block fills up and stalls its pixel input.
  initial begin
    cell_mean_t got;
    int hold_left;
    hold_left = 0;
    out_px.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_px.valid && out_px.ready) begin
        got.red        = out_px.red_out;
        got.green      = out_px.green_out;
        got.blue       = out_px.blue_out;
        got.column     = out_px.cell_column;
        got.row        = out_px.cell_row;
        got.band_last  = out_px.band_last;
        got.frame_last = out_px.frame_last;
        sb.check_result(got);
      end
      if (hold_request && out_px.valid) begin
        hold_request = 0;
        hold_left = 5000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_px.ready <= 1'b0;
      end else begin
        out_px.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Writes a register, then reads it back through the same port.
  task cfg_write(bxavg_pkg::reg_idx_t idx, logic [10:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bxavg_pkg::APB_AW'(4 * int'(idx));
    pwdata  <= bxavg_pkg::APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== bxavg_pkg::APB_DW'(value))
      sb.report($sformatf("register %0d reads %0h, expected %0h", idx, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_px.valid <= 1'b0;
      @(posedge clk);
    end
    in_px.valid    <= 1'b1;
    in_px.red_in   <= r;
    in_px.green_in <= g;
    in_px.blue_in  <= b;
    @(posedge clk);
    while (!in_px.ready) @(posedge clk);
    sb.note_pixel(r, g, b);
    pixels_sent++;
  endtask

  task send_random(int n);
    for (int k = 0; k < n; k++)
      send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  // Drops the pixel request; a pixel that closes no band may still be in flight, so allow
  // its latency to pass.
  task wait_idle();
    in_px.valid <= 1'b0;
    while (sb.expected_means.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    logic [7:0] dir_r[25];
    logic [7:0] dir_g[25];
    logic [7:0] dir_b[25];
    dir_r = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h80, 8'hFE,
              8'h7F, 8'hFF, 8'h00, 8'h0F, 8'hF0, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
              8'h33, 8'hCC, 8'h00, 8'hFF, 8'h80};
    dir_g = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h02, 8'h40, 8'hFD,
              8'h80, 8'hFF, 8'h00, 8'hF0, 8'h0F, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00,
              8'hCC, 8'h33, 8'hFF, 8'h00, 8'h80};
    dir_b = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h04, 8'h20, 8'hFB,
              8'h01, 8'hFF, 8'h00, 8'h3C, 8'hC3, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00,
              8'h99, 8'h66, 8'hFF, 8'h00, 8'h80};
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_px.valid    <= 1'b0;
    in_px.red_in   <= '0;
    in_px.green_in <= '0;
    in_px.blue_in  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // Smallest image, one source row per band.
    cfg_write(bxavg_pkg::REG_SRC_WIDTH, 11'd64);
    cfg_write(bxavg_pkg::REG_SRC_HEIGHT, 11'd64);
    for (int i = 0; i < 25; i++) send_pixel(dir_r[i], dir_g[i], dir_b[i]);
    send_random(64 - 25);
    send_idle_pct = 66;
    hold_request  = 1;
    send_random(64);
    wait_idle();

    // Wider rows with uneven column cells; this row is left open.
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    cfg_write(bxavg_pkg::REG_SRC_WIDTH, 11'd100);
    send_random(70);
    wait_idle();

    // A zero width saturates to the minimum and pins the open row to its last pixel.
    send_idle_pct  = 0;
    recv_stall_pct = 66;
    cfg_write(bxavg_pkg::REG_SRC_WIDTH, 11'd0);
    send_random(12);
    wait_idle();

    $display("Sent %0d pixels in four idling phases; checked %0d cell means over %0d bands.",
             pixels_sent, sb.checked, sb.bands_done);
    $display("Covered a saturated width, a row cut short by a size change and a long hold-off.");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/bxavg_pkg.sv
rtl/core/bxavg_if.sv
rtl/core/bxavg_div.sv
rtl/core/bxavg_dp.sv
rtl/core/bxavg_ctrl.sv
rtl/core/box_average_image_downscale_top.sv
rtl/core/bxavg_chk.sv
tb/tb_box_average_image_downscale_top.sv
